// File: src/atfd_pkg.sv
package atfd_pkg;

  // Target codes for the parameter letter
  localparam logic [3:0] TGT_A       = 4'd0;
  localparam logic [3:0] TGT_B       = 4'd1;
  localparam logic [3:0] TGT_C       = 4'd2;
  localparam logic [3:0] TGT_D       = 4'd3;
  localparam logic [3:0] TGT_E       = 4'd4;
  localparam logic [3:0] TGT_F       = 4'd5;
  localparam logic [3:0] TGT_G       = 4'd6;
  localparam logic [3:0] TGT_H       = 4'd7;
  localparam logic [3:0] TGT_J       = 4'd8;
  localparam logic [3:0] TGT_K       = 4'd9;
  localparam logic [3:0] TGT_X       = 4'd10;
  localparam logic [3:0] TGT_UNKNOWN = 4'd11;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_RANGE    = 3'd1;
  localparam logic [2:0] ST_BADFRAME = 3'd7;

  // Frame delimiters
  localparam logic [7:0] CH_START = 8'h23;  // '#'
  localparam logic [7:0] CH_END   = 8'h2A;  // '*'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

  localparam int VAL_W = 10;  // decimal value 0..999

  // Range limits
  localparam logic [VAL_W-1:0] LIM_PCT     = 10'd100;
  localparam logic [VAL_W-1:0] LIM_B_LO    = 10'd1;
  localparam logic [VAL_W-1:0] LIM_B_HI    = 10'd30;
  localparam logic [VAL_W-1:0] LIM_ANALOG  = 10'd512;
  localparam logic [VAL_W-1:0] X_CODE_LO   = 10'd995;
  localparam logic [10:0]      X_CODE_BASE = 11'd1001;  // 999 -> 2, 995 -> 6

  // Scaling: current = val*26 + floor(2*val/5); voltage = (val*3125) >> 5
  localparam logic [4:0]  CUR_MUL   = 5'd26;
  localparam logic [15:0] RECIP5    = 16'd52429;  // ceil(2^18 / 5)
  localparam int          RECIP5_SH = 18;
  localparam logic [11:0] VOLT_MUL  = 12'd3125;
  localparam int          VOLT_SH   = 5;

  // Parsed frame, output of the first stage
  typedef struct packed {
    logic             ok;
    logic [3:0]       tgt;
    logic [VAL_W-1:0] val;
  } parse_t;

endpackage

// File: src/atfd_parse.sv
module atfd_parse (
  input  logic [7:0]       byte0,
  input  logic [7:0]       byte1,
  input  logic [7:0]       byte2,
  input  logic [7:0]       byte3,
  input  logic [7:0]       byte4,
  input  logic [7:0]       byte5,
  output atfd_pkg::parse_t parse
);
  import atfd_pkg::*;

  logic       dv2, dv3, dv4;
  logic [3:0] d2, d3, d4;
  logic [3:0] tgt;
  logic [VAL_W-1:0] val;

  assign dv2 = (byte2 >= CH_ZERO) && (byte2 <= CH_NINE);
  assign dv3 = (byte3 >= CH_ZERO) && (byte3 <= CH_NINE);
  assign dv4 = (byte4 >= CH_ZERO) && (byte4 <= CH_NINE);
  assign d2  = byte2[3:0];
  assign d3  = byte3[3:0];
  assign d4  = byte4[3:0];

  // First non-digit ends the number
  always_comb begin
    if (!dv2) begin
      val = '0;
    end else if (!dv3) begin
      val = VAL_W'(d2);
    end else if (!dv4) begin
      val = VAL_W'(d2) * VAL_W'(10) + VAL_W'(d3);
    end else begin
      val = VAL_W'(d2) * VAL_W'(100) + VAL_W'(d3) * VAL_W'(10) + VAL_W'(d4);
    end
  end

  always_comb begin
    unique case (byte1)
      8'h41:   tgt = TGT_A;
      8'h42:   tgt = TGT_B;
      8'h43:   tgt = TGT_C;
      8'h44:   tgt = TGT_D;
      8'h45:   tgt = TGT_E;
      8'h46:   tgt = TGT_F;
      8'h47:   tgt = TGT_G;
      8'h48:   tgt = TGT_H;
      8'h4A:   tgt = TGT_J;
      8'h4B:   tgt = TGT_K;
      8'h58:   tgt = TGT_X;
      default: tgt = TGT_UNKNOWN;
    endcase
  end

  assign parse.ok  = (byte0 == CH_START) && (byte5 == CH_END);
  assign parse.tgt = tgt;
  assign parse.val = val;

endmodule

// File: src/ascii_telemetry_frame_decoder.sv
// Pipeline: three register stages (parse, check/multiply, scale); an accepted word moves
// through the stage 1, stage 2 and stage 3 registers and then shows on out_valid.
// Throughput: one frame per cycle while out_ready is high; each stage holds its word only while the next is full.
// The widest path is one 11x16 constant multiply.
// Reset: synchronous, active low rst_n clears the stage valid bits; payload is not reset.
module ascii_telemetry_frame_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte0,
  input  logic [7:0]  in_byte1,
  input  logic [7:0]  in_byte2,
  input  logic [7:0]  in_byte3,
  input  logic [7:0]  in_byte4,
  input  logic [7:0]  in_byte5,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_frame_ok,
  output logic [3:0]  out_target,
  output logic        out_update,
  output logic [15:0] out_scaled_value,
  output logic [2:0]  out_status
);
  import atfd_pkg::*;

  // ---------------------------------------------------------------
  // Stage handshake: a stage loads when empty or when its word moves on
  // ---------------------------------------------------------------
  logic v1_r, v2_r, v3_r;
  logic ld1, ld2, ld3;

  assign ld3      = !v3_r || out_ready;
  assign ld2      = !v2_r || ld3;
  assign ld1      = !v1_r || ld2;
  assign in_ready = ld1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= in_valid;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: delimiter check, letter decode, decimal value
  // ---------------------------------------------------------------
  parse_t parse_nxt, s1_r;

  atfd_parse u_parse (
    .byte0 (in_byte0),
    .byte1 (in_byte1),
    .byte2 (in_byte2),
    .byte3 (in_byte3),
    .byte4 (in_byte4),
    .byte5 (in_byte5),
    .parse (parse_nxt)
  );

  always_ff @(posedge clk) begin
    if (ld1 && in_valid) s1_r <= parse_nxt;
  end

  // ---------------------------------------------------------------
  // Stage 2: range check, status, scaling products
  // ---------------------------------------------------------------
  logic        in_rng;
  logic        upd_nxt;
  logic [2:0]  st_nxt;
  logic [1:0]  cls_nxt;        // bit0 current scaling, bit1 voltage scaling
  logic [14:0] cur_base_nxt;   // val*26
  logic [26:0] cur_frac_nxt;   // (2*val) * RECIP5
  logic [21:0] volt_nxt;       // val*3125
  logic [10:0] x_code;

  logic        ok2_r, upd2_r;
  logic [3:0]  tgt2_r;
  logic [VAL_W-1:0] val2_r;
  logic [2:0]  st2_r;
  logic [1:0]  cls2_r;
  logic [14:0] cur_base_r;
  logic [26:0] cur_frac_r;
  logic [21:0] volt_r;

  always_comb begin
    case (s1_r.tgt) inside
      TGT_A, TGT_H, TGT_J, TGT_K:
        in_rng = (s1_r.val <= LIM_PCT);
      TGT_B:
        in_rng = (s1_r.val >= LIM_B_LO) && (s1_r.val <= LIM_B_HI);
      TGT_C, TGT_D, TGT_E, TGT_F, TGT_G:
        in_rng = (s1_r.val <= LIM_ANALOG);
      default:
        in_rng = 1'b0;
    endcase
  end

  assign x_code = X_CODE_BASE - {1'b0, s1_r.val};

  always_comb begin
    upd_nxt = 1'b0;
    st_nxt  = ST_OK;
    if (!s1_r.ok) begin
      st_nxt = ST_BADFRAME;
    end else if (s1_r.tgt == TGT_X) begin
      // Status codes 999..995 map to 2..6
      if (s1_r.val >= X_CODE_LO) st_nxt = x_code[2:0];
    end else if (s1_r.tgt == TGT_UNKNOWN) begin
      st_nxt = ST_OK;
    end else if (in_rng) begin
      upd_nxt = 1'b1;
    end else begin
      st_nxt = ST_RANGE;
    end
  end

  always_comb begin
    case (s1_r.tgt) inside
      TGT_C, TGT_D, TGT_E: cls_nxt = 2'b01;
      TGT_F, TGT_G:        cls_nxt = 2'b10;
      default:             cls_nxt = 2'b00;
    endcase
  end

  assign cur_base_nxt = 15'(s1_r.val) * 15'(CUR_MUL);
  assign cur_frac_nxt = 27'({s1_r.val, 1'b0}) * 27'(RECIP5);
  assign volt_nxt     = 22'(s1_r.val) * 22'(VOLT_MUL);

  always_ff @(posedge clk) begin
    if (ld2 && v1_r) begin
      ok2_r      <= s1_r.ok;
      tgt2_r     <= s1_r.tgt;
      val2_r     <= s1_r.val;
      upd2_r     <= upd_nxt;
      st2_r      <= st_nxt;
      cls2_r     <= cls_nxt;
      cur_base_r <= cur_base_nxt;
      cur_frac_r <= cur_frac_nxt;
      volt_r     <= volt_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Stage 3: finish scaling, select the value, hold the result word
  // ---------------------------------------------------------------
  logic [16:0] cur_sum;
  logic [16:0] volt_sh;
  logic [15:0] sv_nxt;

  logic        ok3_r, upd3_r;
  logic [3:0]  tgt3_r;
  logic [15:0] sv3_r;
  logic [2:0]  st3_r;

  assign cur_sum = 17'(cur_base_r) + 17'(cur_frac_r >> RECIP5_SH);
  assign volt_sh = 17'(volt_r >> VOLT_SH);

  always_comb begin
    if (!ok2_r) begin
      sv_nxt = '0;
    end else if (upd2_r && cls2_r[0]) begin
      sv_nxt = cur_sum[15:0];
    end else if (upd2_r && cls2_r[1]) begin
      sv_nxt = volt_sh[15:0];
    end else begin
      sv_nxt = 16'(val2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ld3 && v2_r) begin
      ok3_r  <= ok2_r;
      tgt3_r <= tgt2_r;
      upd3_r <= upd2_r;
      sv3_r  <= sv_nxt;
      st3_r  <= st2_r;
    end
  end

  assign out_valid        = v3_r;
  assign out_frame_ok     = ok3_r;
  assign out_target       = tgt3_r;
  assign out_update       = upd3_r;
  assign out_scaled_value = sv3_r;
  assign out_status       = st3_r;

endmodule

// File: verif/tb_top.sv
module tb_top;
  import atfd_pkg::*;

  // Extra status codes for letter X: 999 -> 2 ... 995 -> 6
  localparam logic [2:0] ST_X_FIRST = 3'd2;
  localparam int         X_CODE_HI  = 999;
  localparam int         X_CODE_LO_I = 995;

  // Current and voltage scale factors as the data sheet gives them
  localparam longint CUR_NUM  = 264;
  localparam longint CUR_DEN  = 10;
  localparam longint VOLT_NUM = 9765625;
  localparam longint VOLT_DEN = 100000;

  localparam int MAX_REPORTS  = 10;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;

  // Letters the decoder knows, in target order, X last
  localparam logic [7:0] LETTERS [11] = '{"A", "B", "C", "D", "E", "F", "G", "H", "J", "K",
                                          "X"};

  // One frame: index 0 is the first byte on the wire
  typedef logic [5:0][7:0] frame_t;

  typedef struct packed {
    logic        frame_ok;
    logic [3:0]  target;
    logic        update;
    logic [15:0] scaled_value;
    logic [2:0]  status;
  } telemetry_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte0, in_byte1, in_byte2, in_byte3, in_byte4, in_byte5;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_frame_ok;
  logic [3:0]  out_target;
  logic        out_update;
  logic [15:0] out_scaled_value;
  logic [2:0]  out_status;

  // Decoded readings still owed by the block, oldest first
  telemetry_t pending_readings[$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_off_on    = 1'b0;
  int hold_off_count = 0;

  ascii_telemetry_frame_decoder i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte0         (in_byte0),
    .in_byte1         (in_byte1),
    .in_byte2         (in_byte2),
    .in_byte3         (in_byte3),
    .in_byte4         (in_byte4),
    .in_byte5         (in_byte5),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_ok     (out_frame_ok),
    .out_target       (out_target),
    .out_update       (out_update),
    .out_scaled_value (out_scaled_value),
    .out_status       (out_status)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Map the parameter letter to its target code; anything else is unknown,
  // lower case included.
  function automatic logic [3:0] letter_target(logic [7:0] letter);
    case (letter)
      "A": return TGT_A;
      "B": return TGT_B;
      "C": return TGT_C;
      "D": return TGT_D;
      "E": return TGT_E;
      "F": return TGT_F;
      "G": return TGT_G;
      "H": return TGT_H;
      "J": return TGT_J;
      "K": return TGT_K;
      "X": return TGT_X;
      default: return TGT_UNKNOWN;
    endcase
  endfunction

  // Work out the reading the block must report for one frame.
  function automatic telemetry_t decode_frame(frame_t f);
    telemetry_t r;
    int         value;
    bit         in_num;
    value  = 0;
    in_num = 1'b1;
    // Read up to three digits; the first non-digit ends the number
    for (int i = 2; i <= 4; i++) begin
      if (in_num && f[i] >= CH_ZERO && f[i] <= CH_NINE)
        value = value * 10 + int'(f[i] - CH_ZERO);
      else
        in_num = 1'b0;
    end
    r.frame_ok     = (f[0] == CH_START) && (f[5] == CH_END);
    r.target       = letter_target(f[1]);
    r.update       = 1'b0;
    r.scaled_value = 16'(value);
    r.status       = ST_OK;
    if (!r.frame_ok) begin
      r.scaled_value = '0;
      r.status       = ST_BADFRAME;
    end else begin
      case (r.target) inside
        TGT_A, TGT_H, TGT_J, TGT_K: begin
          if (value <= 100) r.update = 1'b1;
          else r.status = ST_RANGE;
        end
        TGT_B: begin
          if (value >= 1 && value <= 30) r.update = 1'b1;
          else r.status = ST_RANGE;
        end
        TGT_C, TGT_D, TGT_E: begin
          if (value <= 512) begin
            r.update       = 1'b1;
            r.scaled_value = 16'((longint'(value) * CUR_NUM) / CUR_DEN);
          end else begin
            r.status = ST_RANGE;
          end
        end
        TGT_F, TGT_G: begin
          if (value <= 512) begin
            r.update       = 1'b1;
            r.scaled_value = 16'((longint'(value) * VOLT_NUM) / VOLT_DEN);
          end else begin
            r.status = ST_RANGE;
          end
        end
        TGT_X: begin
          if (value >= X_CODE_LO_I && value <= X_CODE_HI)
            r.status = ST_X_FIRST + 3'(X_CODE_HI - value);
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  function automatic frame_t build_frame(logic [7:0] letter, int value);
    frame_t f;
    f[0] = CH_START;
    f[1] = letter;
    f[2] = CH_ZERO + 8'(value / 100);
    f[3] = CH_ZERO + 8'((value / 10) % 10);
    f[4] = CH_ZERO + 8'(value % 10);
    f[5] = CH_END;
    return f;
  endfunction

  // Mostly well-formed frames with values near the range edges, plus some
  // with one corrupted byte and some that are pure noise.
  function automatic frame_t random_frame();
    frame_t f;
    int     value;
    int     kind;
    kind = $urandom_range(99);
    case ($urandom_range(3))
      0: value = $urandom_range(999);
      1: value = $urandom_range(120);
      2: value = $urandom_range(530, 490);
      default: value = $urandom_range(999, 985);
    endcase
    f = build_frame(LETTERS[$urandom_range(10)], value);
    if (kind >= 88) begin
      for (int i = 0; i < 6; i++) f[i] = 8'($urandom_range(255));
    end else if (kind >= 72) begin
      f[$urandom_range(5)] = 8'($urandom_range(255));
    end
    return f;
  endfunction

  // Offer one word, with a random gap first, and hold it until taken.
  // Returns on the edge that accepts it, with in_valid still high.
  task automatic send_frame(frame_t f);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte0 <= f[0];
    in_byte1 <= f[1];
    in_byte2 <= f[2];
    in_byte3 <= f[3];
    in_byte4 <= f[4];
    in_byte5 <= f[5];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_readings.push_back(decode_frame(f));
  endtask

  task automatic test_directed();
    frame_t f;
    // Range edges of every letter class
    send_frame(build_frame("A", 0));
    send_frame(build_frame("A", 100));
    send_frame(build_frame("H", 101));
    send_frame(build_frame("B", 0));
    send_frame(build_frame("B", 1));
    send_frame(build_frame("J", 30));
    send_frame(build_frame("B", 31));
    send_frame(build_frame("C", 512));
    send_frame(build_frame("D", 513));
    send_frame(build_frame("E", 1));
    send_frame(build_frame("F", 512));
    send_frame(build_frame("G", 0));
    send_frame(build_frame("K", 999));
    // Status codes of letter X, and one value just outside them
    for (int v = X_CODE_LO_I - 1; v <= X_CODE_HI; v++) send_frame(build_frame("X", v));
    // Lower-case letter is unknown
    send_frame(build_frame("a", 42));
    // Broken start and end delimiters
    f = build_frame("C", 200);
    f[0] = 8'hFF;
    send_frame(f);
    f = build_frame("F", 300);
    f[5] = 8'h00;
    send_frame(f);
    // Non-digit in the hundreds, tens and units positions
    f = build_frame("A", 55);
    f[2] = " ";
    send_frame(f);
    f = build_frame("G", 456);
    f[3] = "/";
    send_frame(f);
    f = build_frame("C", 456);
    f[4] = ":";
    send_frame(f);
  endtask

  task automatic test_random(int count, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) send_frame(random_frame());
  endtask

  // Hold the result side off for a long stretch while frames keep coming,
  // so the pipeline fills and in_ready drops.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_on    = 1'b1;
    for (int n = 0; n < 40; n++) send_frame(random_frame());
    hold_off_on    = 1'b0;
  endtask

  // Result side: check each word taken at this edge.
  always @(posedge clk) begin
    telemetry_t got;
    telemetry_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_frame_ok, out_target, out_update, out_scaled_value, out_status};
      if (pending_readings.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected word: ok=%0d tgt=%0d upd=%0d val=%0d st=%0d",
                   got.frame_ok, got.target, got.update, got.scaled_value, got.status);
      end else begin
        want = pending_readings.pop_front();
        if (got.frame_ok !== want.frame_ok || got.target !== want.target ||
            got.update !== want.update || got.scaled_value !== want.scaled_value ||
            got.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display({"mismatch: exp ok=%0d tgt=%0d upd=%0d val=%0d st=%0d",
                      " | got ok=%0d tgt=%0d upd=%0d val=%0d st=%0d"},
                     want.frame_ok, want.target, want.update, want.scaled_value,
                     want.status, got.frame_ok, got.target, got.update,
                     got.scaled_value, got.status);
        end
      end
    end
  end

  // Pick the next value of out_ready; count the hold-off here so it runs
  // while the sender is blocked
  always @(posedge clk) begin
    if (hold_off_on && hold_off_count < HOLD_CYCLES) begin
      out_ready      <= 1'b0;
      hold_off_count <= hold_off_count + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!hold_off_on) hold_off_count <= 0;
    end
  end

  // Watchdog: end the run with errors once cycle_count passes CYCLE_LIMIT
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_byte0 = '0;
    in_byte1 = '0;
    in_byte2 = '0;
    in_byte3 = '0;
    in_byte4 = '0;
    in_byte5 = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(220, 0, 0);
    test_random(200, 54, 0);
    test_random(200, 0, 54);
    test_random(200, 30, 30);
    test_backpressure();
    test_random(40, 0, 0);
    in_valid <= 1'b0;

    // Drain, then keep watching the output for stray words
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_readings.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
